### rtl/core/bnsu_pkg.sv
// Shared types and constants for the Boolean network update unit.
// No dependencies; used by the interfaces and imported by every module of the block.
package bnsu_pkg;

  localparam int MAX_NODES  = 64;
  localparam int FAN_IN     = 3;
  localparam int TRUTH_LEN  = 1 << FAN_IN;
  localparam int NODE_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CONN_SEL_W = (FAN_IN > 1) ? $clog2(FAN_IN) : 1;

  // fixed field widths
  localparam int CMD_W    = 3;
  localparam int NIDX_W   = 6;
  localparam int SLOT_W   = 3;
  localparam int SRC_W    = 6;
  localparam int WORD_W   = 64;
  localparam int COUNT_W  = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_INPUTS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_OUTPUTS = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_STEP       = 3'd0,
    CMD_FORCE_ONE  = 3'd1,
    CMD_FORCE_MANY = 3'd2,
    CMD_CLEAR      = 3'd3,
    CMD_WR_CONN    = 3'd4,
    CMD_WR_TRUTH   = 3'd5
  } cmd_t;

  typedef logic [FAN_IN-1:0][SRC_W-1:0] conn_row_t;
  typedef logic [TRUTH_LEN-1:0]          truth_row_t;

  typedef struct packed {
    logic                  conn_we;
    logic                  truth_we;
    logic [NODE_W-1:0]     addr;
    logic [CONN_SEL_W-1:0] conn_sel;
    logic [SRC_W-1:0]      conn_data;
    logic [FAN_IN-1:0]     truth_sel;
    logic                  truth_data;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
  } tbl_rd_t;

endpackage

### rtl/core/bnsu_if.sv
// Handshake channels of the Boolean network update unit: request, result, config.
// Depends on bnsu_pkg for field widths.
interface bnsu_in_if;
  logic                             valid;
  logic                             ready;
  logic [bnsu_pkg::CMD_W-1:0]       command;
  logic [bnsu_pkg::NIDX_W-1:0]      node_index;
  logic [bnsu_pkg::SLOT_W-1:0]      slot_index;
  logic [bnsu_pkg::SRC_W-1:0]       source_node;
  logic                             bit_value;
  logic [bnsu_pkg::WORD_W-1:0]      forced_bits;
  logic [bnsu_pkg::COUNT_W-1:0]     forced_count;

  modport source (output valid, command, node_index, slot_index, source_node,
                  bit_value, forced_bits, forced_count, input ready);
  modport sink   (input valid, command, node_index, slot_index, source_node,
                  bit_value, forced_bits, forced_count, output ready);
endinterface

interface bnsu_out_if;
  logic                        valid;
  logic                        ready;
  logic [bnsu_pkg::WORD_W-1:0] output_bits;
  logic [bnsu_pkg::WORD_W-1:0] input_bits;
  logic                        status;

  modport source (output valid, output_bits, input_bits, status, input ready);
  modport sink   (input valid, output_bits, input_bits, status, output ready);
endinterface

interface bnsu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bnsu_pkg::CFG_IDX_W-1:0] index;
  logic [bnsu_pkg::COUNT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/bnsu_tables.sv
// Connection and truth-table memories, one row per node, registered read port.
// Depends on bnsu_pkg.
module bnsu_tables (
  input  logic                 clk,
  input  bnsu_pkg::tbl_wr_t    wr,
  input  bnsu_pkg::tbl_rd_t    rd,
  output bnsu_pkg::conn_row_t  conn_q,
  output bnsu_pkg::truth_row_t truth_q
);
  import bnsu_pkg::*;

  conn_row_t  conn_mem  [MAX_NODES];
  truth_row_t truth_mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (wr.conn_we) begin
      conn_mem[wr.addr][wr.conn_sel] <= wr.conn_data;
    end
    if (wr.truth_we) begin
      truth_mem[wr.addr][wr.truth_sel] <= wr.truth_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      conn_q  <= conn_mem[rd.addr];
      truth_q <= truth_mem[rd.addr];
    end
  end

endmodule

### rtl/core/bnsu_node_eval.sv
// Next-state bit of one node from its table rows and the old network state.
// Depends on bnsu_pkg.
module bnsu_node_eval (
  input  bnsu_pkg::conn_row_t       conn_row,
  input  bnsu_pkg::truth_row_t      truth_row,
  input  logic [bnsu_pkg::WORD_W-1:0]  old_state,
  input  logic [bnsu_pkg::COUNT_W-1:0] eff_nodes,
  output logic                      new_bit
);
  import bnsu_pkg::*;

  logic [FAN_IN-1:0] idx;

  always_comb begin
    for (int s = 0; s < FAN_IN; s++) begin
      // sources outside the active network read as zero
      idx[s] = ({1'b0, conn_row[s]} < eff_nodes) ? old_state[conn_row[s]] : 1'b0;
    end
  end

  assign new_bit = truth_row[idx];

endmodule

### rtl/core/boolean_network_sync_update_unit.sv
// Boolean network update unit, top level: command sequencer, state register, result.
// A step reads the table rows of each active node in turn, evaluates and writes back each
//   node's bit, commits the new state, then loads the result; others go straight to the load.
// The request port reopens once the result is loaded, even if it is not yet taken, so a new
//   request is taken only after the last is through. A result that is not taken holds the
//   next result load. Reset clears node states and restores the register defaults; the
//   table memories are not cleared.
module boolean_network_sync_update_unit (
  input logic       clk,
  input logic       rst_n,
  bnsu_in_if.sink   in_ch,
  bnsu_out_if.source out_ch,
  bnsu_cfg_if.sink  cfg_ch
);
  import bnsu_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_FIN} state_t;

  state_t              state_r;
  logic [COUNT_W-1:0]  node_count_r, num_inputs_r, num_outputs_r;
  logic [WORD_W-1:0]   node_state_r, next_r;
  logic [COUNT_W-1:0]  rd_idx_r;
  logic                pend_r;
  logic [NIDX_W-1:0]   wb_idx_r;
  logic                status_r;
  cmd_t                cmd_r;
  logic                out_valid_r;
  logic [WORD_W-1:0]   obits_r, ibits_r;
  logic                out_status_r;

  logic [COUNT_W-1:0]  eff_nodes, eff_in, eff_out;
  logic                in_acc, step_done, rd_go, new_bit;
  logic                force_rej, out_load, out_valid_nxt;
  logic [WORD_W-1:0]   obits_nxt, ibits_nxt, fm_mask;
  cmd_t                cmd_in;
  tbl_wr_t             wr;
  tbl_rd_t             rd;
  conn_row_t           conn_q;
  truth_row_t          truth_q;

  assign eff_nodes = (node_count_r > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : node_count_r;
  assign eff_in    = (num_inputs_r  > eff_nodes) ? eff_nodes : num_inputs_r;
  assign eff_out   = (num_outputs_r > eff_nodes) ? eff_nodes : num_outputs_r;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cmd_in       = cmd_t'(in_ch.command);

  // force outside the declared inputs
  assign force_rej = ((cmd_in == CMD_FORCE_ONE) && ({1'b0, in_ch.node_index} >= eff_in)) ||
                     ((cmd_in == CMD_FORCE_MANY) && (in_ch.forced_count > eff_in));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= COUNT_W'(64);
      num_inputs_r  <= '0;
      num_outputs_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_NODE_COUNT:  node_count_r  <= cfg_ch.data;
        CFG_NUM_INPUTS:  num_inputs_r  <= cfg_ch.data;
        CFG_NUM_OUTPUTS: num_outputs_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // table write port, driven in the cycle a write request is accepted
  always_comb begin
    wr            = '0;
    wr.addr       = in_ch.node_index[NODE_W-1:0];
    wr.conn_sel   = CONN_SEL_W'(in_ch.slot_index);
    wr.conn_data  = in_ch.source_node;
    wr.truth_sel  = FAN_IN'(in_ch.slot_index);
    wr.truth_data = in_ch.bit_value;
    if (in_acc && ({1'b0, in_ch.node_index} < COUNT_W'(MAX_NODES))) begin
      wr.conn_we  = (cmd_in == CMD_WR_CONN)  && (int'(in_ch.slot_index) < FAN_IN);
      wr.truth_we = (cmd_in == CMD_WR_TRUTH) && (int'(in_ch.slot_index) < TRUTH_LEN);
    end
  end

  assign rd_go     = (state_r == ST_STEP) && (rd_idx_r < eff_nodes);
  assign rd        = {rd_go, rd_idx_r[NODE_W-1:0]};
  assign step_done = (state_r == ST_STEP) && !rd_go && !pend_r;

  bnsu_tables u_tables (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .conn_q  (conn_q),
    .truth_q (truth_q)
  );

  bnsu_node_eval u_eval (
    .conn_row  (conn_q),
    .truth_row (truth_q),
    .old_state (node_state_r),
    .eff_nodes (eff_nodes),
    .new_bit   (new_bit)
  );

  assign fm_mask = (WORD_W'(1) << in_ch.forced_count) - WORD_W'(1);

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      obits_nxt[j] = (COUNT_W'(j) < eff_out) ?
                     node_state_r[NIDX_W'(eff_nodes - COUNT_W'(1) - COUNT_W'(j))] : 1'b0;
      ibits_nxt[j] = (COUNT_W'(j) < eff_in) ? node_state_r[j] : 1'b0;
    end
  end

  assign out_load      = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_state_r <= '0;
      rd_idx_r     <= '0;
      pend_r       <= 1'b0;
      status_r     <= 1'b0;
      cmd_r        <= CMD_STEP;
      out_valid_r  <= 1'b0;
      out_status_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r    <= cmd_in;
            status_r <= force_rej;
            state_r  <= (cmd_in == CMD_STEP) ? ST_STEP : ST_FIN;
            case (cmd_in)
              CMD_STEP: begin
                next_r   <= node_state_r;
                rd_idx_r <= '0;
                pend_r   <= 1'b0;
              end
              CMD_FORCE_ONE: begin
                if (!force_rej) begin
                  node_state_r[in_ch.node_index] <= in_ch.bit_value;
                end
              end
              CMD_FORCE_MANY: begin
                if (!force_rej) begin
                  node_state_r <= (node_state_r & ~fm_mask) | (in_ch.forced_bits & fm_mask);
                end
              end
              CMD_CLEAR: node_state_r <= '0;
              default: ;
            endcase
          end
        end
        ST_STEP: begin
          // read issued this cycle, evaluated and written back the next
          pend_r <= rd_go;
          if (rd_go) begin
            rd_idx_r <= rd_idx_r + COUNT_W'(1);
            wb_idx_r <= rd_idx_r[NIDX_W-1:0];
          end
          if (pend_r) begin
            next_r[wb_idx_r] <= new_bit;
          end
          if (step_done) begin
            node_state_r <= next_r;
            state_r      <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            obits_r      <= obits_nxt;
            ibits_r      <= ibits_nxt;
            out_status_r <= status_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.output_bits = obits_r;
  assign out_ch.input_bits  = ibits_r;
  assign out_ch.status      = out_status_r;

  // old state must hold while the step still reads it
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && !step_done) |=> $stable(node_state_r))
    else $error("node state changed during step");

  assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ({1'b0, wb_idx_r} + COUNT_W'(1) == rd_idx_r))
    else $error("write-back index out of step with read index");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ch.ready) |=> (state_r == ST_FIN))
    else $error("result overwritten before taken");

  assert property (@(posedge clk) disable iff (!rst_n)
    status_r |-> (cmd_r == CMD_FORCE_ONE || cmd_r == CMD_FORCE_MANY))
    else $error("reject status on a non-force request");

endmodule

### bench/tb_boolean_network_sync_update_unit.sv
// Testbench for boolean_network_sync_update_unit: sends network commands and register
// writes over the bnsu_if channels and checks each result against an in-bench network.
// Depends on bnsu_pkg and bnsu_if (interfaces) plus the RTL of the block.
module tb_boolean_network_sync_update_unit;
  import bnsu_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = MAX_NODES + 8;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [NIDX_W-1:0]  node_index;
    logic [SLOT_W-1:0]  slot_index;
    logic [SRC_W-1:0]   source_node;
    logic               bit_value;
    logic [WORD_W-1:0]  forced_bits;
    logic [COUNT_W-1:0] forced_count;
  } net_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] output_bits;
    logic [WORD_W-1:0] input_bits;
    logic              status;
  } readout_t;

  logic clk = 1'b0;
  logic rst_n;

  bnsu_in_if  in_ch();
  bnsu_out_if out_ch();
  bnsu_cfg_if cfg_ch();

  boolean_network_sync_update_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // mirror of the network held by the block
  logic [COUNT_W-1:0]   net_nodes   = COUNT_W'(MAX_NODES);
  logic [COUNT_W-1:0]   net_inputs  = '0;
  logic [COUNT_W-1:0]   net_outputs = '0;
  logic [MAX_NODES-1:0] node_bits   = '0;
  logic [SRC_W-1:0]     src_tbl   [MAX_NODES*FAN_IN];
  logic                 truth_tbl [MAX_NODES*TRUTH_LEN];

  readout_t readout_q[$];
  readout_t head_ro;
  int       fail_cnt     = 0;
  int       stall_cycles = 0;
  bit       idle_on      = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned active_nodes();
    return (net_nodes > MAX_NODES) ? MAX_NODES : net_nodes;
  endfunction

  function automatic int unsigned clip_to_nodes(input int unsigned v);
    return (v > active_nodes()) ? active_nodes() : v;
  endfunction

  // applies one request to the mirror and returns the readout it should produce
  function automatic readout_t run_command(input net_req_t r);
    int unsigned n, n_in, n_out, idx;
    int j, s;
    logic [MAX_NODES-1:0] prev;
    readout_t ro;
    n = active_nodes();
    n_in = clip_to_nodes(net_inputs);
    n_out = clip_to_nodes(net_outputs);
    ro = '0;
    case (r.command)
      CMD_STEP: begin
        prev = node_bits;
        for (j = 0; j < n; j++) begin
          idx = 0;
          for (s = 0; s < FAN_IN; s++)
            if (src_tbl[j*FAN_IN+s] < n && prev[src_tbl[j*FAN_IN+s]]) idx |= 1 << s;
          node_bits[j] = truth_tbl[j*TRUTH_LEN+idx];
        end
      end
      CMD_FORCE_ONE: begin
        if (r.node_index >= n_in) ro.status = 1'b1;
        else node_bits[r.node_index] = r.bit_value;
      end
      CMD_FORCE_MANY: begin
        if (r.forced_count > n_in) ro.status = 1'b1;
        else for (j = 0; j < r.forced_count; j++) node_bits[j] = r.forced_bits[j];
      end
      CMD_CLEAR: node_bits = '0;
      CMD_WR_CONN: begin
        if (r.slot_index < FAN_IN) src_tbl[r.node_index*FAN_IN+r.slot_index] = r.source_node;
      end
      CMD_WR_TRUTH: begin
        if (r.slot_index < TRUTH_LEN)
          truth_tbl[r.node_index*TRUTH_LEN+r.slot_index] = r.bit_value;
      end
      default: ;
    endcase
    for (j = 0; j < n_out; j++) ro.output_bits[j] = node_bits[n-1-j];
    for (j = 0; j < n_in; j++) ro.input_bits[j] = node_bits[j];
    return ro;
  endfunction

  // fields a command does not use are random, so every bit still toggles
  function automatic net_req_t rand_req(input logic [CMD_W-1:0] c);
    net_req_t r;
    r.command      = c;
    r.node_index   = NIDX_W'($urandom_range(MAX_NODES-1));
    r.slot_index   = SLOT_W'($urandom_range(7));
    r.source_node  = SRC_W'($urandom_range(63));
    r.bit_value    = 1'($urandom_range(1));
    r.forced_bits  = {$urandom, $urandom};
    r.forced_count = COUNT_W'($urandom_range(127));
    return r;
  endfunction

  task automatic send_req(input net_req_t r);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= r.command;
    in_ch.node_index   <= r.node_index;
    in_ch.slot_index   <= r.slot_index;
    in_ch.source_node  <= r.source_node;
    in_ch.bit_value    <= r.bit_value;
    in_ch.forced_bits  <= r.forced_bits;
    in_ch.forced_count <= r.forced_count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    readout_q.push_back(run_command(r));
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] c);
    send_req(rand_req(c));
  endtask

  task automatic force_one(input int unsigned idx, input logic b);
    net_req_t r;
    r = rand_req(CMD_FORCE_ONE);
    r.node_index = NIDX_W'(idx);
    r.bit_value = b;
    send_req(r);
  endtask

  task automatic force_many(input int unsigned cnt, input logic [WORD_W-1:0] bits);
    net_req_t r;
    r = rand_req(CMD_FORCE_MANY);
    r.forced_count = COUNT_W'(cnt);
    r.forced_bits = bits;
    send_req(r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_NODE_COUNT:  net_nodes = val;
      CFG_NUM_INPUTS:  net_inputs = val;
      CFG_NUM_OUTPUTS: net_outputs = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_config(input int unsigned nodes, input int unsigned ins,
                            input int unsigned outs);
    wait_idle();
    write_reg(CFG_NODE_COUNT, COUNT_W'(nodes));
    write_reg(CFG_NUM_INPUTS, COUNT_W'(ins));
    write_reg(CFG_NUM_OUTPUTS, COUNT_W'(outs));
  endtask

  // reset defaults: no inputs declared, so every nonempty force is rejected
  task automatic test_idle_commands();
    send_cmd(CMD_CLEAR);
    force_one(0, 1'b1);
    force_many(1, '1);
    force_many(0, '1);
    send_cmd(CMD_SPARE_6);
    send_cmd(CMD_SPARE_7);
  endtask

  // every table entry is written before the first step reads it
  task automatic load_tables();
    net_req_t r;
    int node, k;
    for (node = 0; node < MAX_NODES; node++)
      for (k = 0; k < FAN_IN; k++) begin
        r = rand_req(CMD_WR_CONN);
        r.node_index = NIDX_W'(node);
        r.slot_index = SLOT_W'(k);
        send_req(r);
      end
    // slots past the fan-in are dropped
    r = rand_req(CMD_WR_CONN);
    r.slot_index = SLOT_W'(FAN_IN);
    send_req(r);
    r.slot_index = '1;
    send_req(r);
    for (node = 0; node < MAX_NODES; node++)
      for (k = 0; k < TRUTH_LEN; k++) begin
        r = rand_req(CMD_WR_TRUTH);
        r.node_index = NIDX_W'(node);
        r.slot_index = SLOT_W'(k);
        send_req(r);
      end
  endtask

  task automatic test_forces();
    set_config(MAX_NODES, MAX_NODES, MAX_NODES);
    force_one(0, 1'b1);
    force_one(MAX_NODES-1, 1'b1);
    force_many(MAX_NODES, {$urandom, $urandom});
    force_many(MAX_NODES+1, '0);
    force_many(127, '1);
    set_config(MAX_NODES, 10, 5);
    force_one(10, 1'b1);
    force_one(9, 1'b0);
    force_one(MAX_NODES-1, 1'b1);
  endtask

  task automatic test_steps();
    set_config(MAX_NODES, MAX_NODES, MAX_NODES);
    repeat (3) send_cmd(CMD_STEP);
    // small network: most sources fall outside, upper nodes hold their bits
    set_config(5, 3, 3);
    force_one(2, 1'b1);
    repeat (2) send_cmd(CMD_STEP);
    set_config(0, MAX_NODES, MAX_NODES);
    send_cmd(CMD_STEP);
    force_one(0, 1'b1);
    send_cmd(CMD_CLEAR);
    set_config(1, 127, 127);
    send_cmd(CMD_STEP);
    set_config(127, 127, 127);
    repeat (2) send_cmd(CMD_STEP);
  endtask

  task automatic test_random();
    net_req_t r;
    int unsigned pick, n_in;
    int ph, k;
    for (ph = 0; ph < 10; ph++) begin
      idle_on = (ph < 4 || ph > 6);
      case (ph)
        0: set_config(MAX_NODES, MAX_NODES, MAX_NODES);
        1: set_config(1, 1, 1);
        2: set_config(0, 5, 5);
        3: set_config(127, 127, 127);
        default: set_config($urandom_range(2, MAX_NODES), $urandom_range(0, 70),
                            $urandom_range(0, 70));
      endcase
      for (k = 0; k < ((ph == 2) ? 20 : 100); k++) begin
        n_in = clip_to_nodes(net_inputs);
        pick = $urandom_range(99);
        if (pick < 45) begin
          r = rand_req(CMD_STEP);
        end else if (pick < 60) begin
          r = rand_req(CMD_FORCE_ONE);
          if (n_in > 0 && $urandom_range(9) != 0)
            r.node_index = NIDX_W'($urandom_range(n_in-1));
        end else if (pick < 72) begin
          r = rand_req(CMD_FORCE_MANY);
          if ($urandom_range(9) != 0) r.forced_count = COUNT_W'($urandom_range(n_in));
        end else if (pick < 76) begin
          r = rand_req(CMD_CLEAR);
        end else if (pick < 86) begin
          r = rand_req(CMD_WR_CONN);
        end else if (pick < 96) begin
          r = rand_req(CMD_WR_TRUTH);
        end else begin
          r = rand_req($urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7);
        end
        send_req(r);
      end
    end
    idle_on = 1'b1;
  endtask

  always @(negedge clk) begin
    out_ch.ready <= !(idle_on && $urandom_range(99) < 31);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (readout_q.size() == 0) begin
        $error("result with no request pending");
        fail_cnt++;
      end else begin
        head_ro = readout_q.pop_front();
        if (out_ch.output_bits !== head_ro.output_bits) begin
          $error("output_bits: expected %h, got %h", head_ro.output_bits, out_ch.output_bits);
          fail_cnt++;
        end
        if (out_ch.input_bits !== head_ro.input_bits) begin
          $error("input_bits: expected %h, got %h", head_ro.input_bits, out_ch.input_bits);
          fail_cnt++;
        end
        if (out_ch.status !== head_ro.status) begin
          $error("status: expected %0d, got %0d", head_ro.status, out_ch.status);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.node_index = '0;
    in_ch.slot_index = '0;
    in_ch.source_node = '0;
    in_ch.bit_value = 1'b0;
    in_ch.forced_bits = '0;
    in_ch.forced_count = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_commands();
    load_tables();
    test_forces();
    test_steps();
    test_random();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && readout_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
